[hdl/fds_pkg.sv]
// ----------------------------------------------------------------------------
// fds_pkg
// Shared types and constants of the frame data stack: field widths, action
// and status codes, and the memory command.
// ----------------------------------------------------------------------------
package fds_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int ITEM_WIDTH_DEF  = 64;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 64;
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int DEPTH_W  = 11;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH    = 3'd0,
        ACT_RESERVE = 3'd1,
        ACT_POP     = 3'd2,
        ACT_READ    = 3'd3,
        ACT_WRITE   = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } ram_cmd_t;

endpackage

[hdl/fds_if.sv]
// ----------------------------------------------------------------------------
// fds_if
// Valid/ready channels of the frame data stack: the request channel and the
// result channel.
// ----------------------------------------------------------------------------
interface fds_req_if;
    logic                         valid;
    logic                         ready;
    logic [fds_pkg::ACTION_W-1:0] action;
    logic [fds_pkg::VALUE_W-1:0]  item_value;
    logic [fds_pkg::COUNT_W-1:0]  slot_count;
    logic [fds_pkg::INDEX_W-1:0]  slot_index;

    modport source (output valid, action, item_value, slot_count, slot_index,
                    input ready);
    modport sink (input valid, action, item_value, slot_count, slot_index,
                  output ready);
endinterface

interface fds_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fds_pkg::VALUE_W-1:0]  read_data;
    logic [fds_pkg::DEPTH_W-1:0]  depth;
    logic [fds_pkg::STATUS_W-1:0] status;

    modport source (output valid, read_data, depth, status, input ready);
    modport sink (input valid, read_data, depth, status, output ready);
endinterface

[hdl/frame_data_stack_unit.sv]
// ----------------------------------------------------------------------------
// frame_data_stack_unit
// Interpreter data stack in a synchronous slot memory with push, reserve,
// pop, indexed read and indexed write.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one request per handshake: an action code, a value,
// a slot count and a slot index. The rsp channel returns exactly one result
// per request: read data (zero unless a read succeeds), the depth after the
// action, and a status code. Refused requests leave the stack unchanged.
// The result of a request is registered at the edge that accepts it.
// Throughput is one request per cycle while rsp is ready, set by the single
// memory port, which serves at most one write or one read per request; a read
// returns its data from the memory's output register on the next cycle.
// Reset clears the stack pointer and the result valid flag; the slot memory is
// not cleared and slots hold undefined data until written.
// When the receiver stalls, the pending result is held and req.ready drops
// until it is taken; the memory read register holds its data meanwhile.
// ----------------------------------------------------------------------------
module frame_data_stack_unit #(
    parameter int STACK_DEPTH = fds_pkg::STACK_DEPTH_DEF,
    parameter int ITEM_WIDTH  = fds_pkg::ITEM_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fds_req_if.sink   req,
    fds_rsp_if.source rsp
);

    localparam int AW = $clog2(STACK_DEPTH);

    fds_pkg::ram_cmd_t     ram_cmd;
    logic [AW-1:0]         ram_addr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    fds_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .ITEM_WIDTH  (ITEM_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_cmd   (ram_cmd),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    fds_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (ITEM_WIDTH)
    ) u_ram (
        .clk   (clk),
        .cmd   (ram_cmd),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    a_stall_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
        else $error("request taken while a result is stalled");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> rsp.valid)
        else $error("accepted request produced no result");

    a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != fds_pkg::ST_OK |-> rsp.read_data == '0)
        else $error("refused request returned read data");

    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_cmd.wr && ram_cmd.rd))
        else $error("memory read and write issued together");
`endif

endmodule

[hdl/fds_ram.sv]
// ----------------------------------------------------------------------------
// fds_ram
// Single-port synchronous slot memory with a registered read port.
// ----------------------------------------------------------------------------
module fds_ram #(
    parameter int DEPTH = fds_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH = fds_pkg::ITEM_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic              clk,
    input  fds_pkg::ram_cmd_t cmd,
    input  logic [AW-1:0]     addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/fds_ctrl.sv]
// ----------------------------------------------------------------------------
// fds_ctrl
// Stack pointer, request checking, memory command issue and the result
// register stage.
// ----------------------------------------------------------------------------
module fds_ctrl #(
    parameter int STACK_DEPTH = fds_pkg::STACK_DEPTH_DEF,
    parameter int ITEM_WIDTH  = fds_pkg::ITEM_WIDTH_DEF,
    localparam int AW         = $clog2(STACK_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    fds_req_if.sink               req,
    fds_rsp_if.source             rsp,
    output fds_pkg::ram_cmd_t     ram_cmd,
    output logic [AW-1:0]         ram_addr,
    output logic [ITEM_WIDTH-1:0] ram_wdata,
    input  logic [ITEM_WIDTH-1:0] ram_rdata
);

    localparam int TW = $clog2(STACK_DEPTH + 1);
    localparam int CW = ((TW > fds_pkg::COUNT_W) ? TW : fds_pkg::COUNT_W) + 1;

    logic                         accept;
    logic [TW-1:0]                top_reg;
    logic [TW-1:0]                top_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    fds_pkg::status_t             status_reg;
    fds_pkg::status_t             status_next;
    logic [fds_pkg::DEPTH_W-1:0]  depth_reg;
    logic                         rd_ok_reg;
    logic                         rd_ok_next;
    logic [CW-1:0]                top_w;
    logic [CW-1:0]                cnt_w;
    logic [CW-1:0]                idx_w;
    logic [CW-1:0]                cap_w;
    logic [CW-1:0]                addr_w;
    logic [CW-1:0]                top_upd;
    logic [fds_pkg::VALUE_W-1:0]  rdata_ext;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign top_w = CW'(top_reg);
    assign cnt_w = CW'(req.slot_count);
    assign idx_w = CW'(req.slot_index);
    assign cap_w = CW'(STACK_DEPTH);

    always_comb
    begin
        status_next = fds_pkg::ST_OK;
        rd_ok_next  = 1'b0;
        ram_cmd     = '0;
        addr_w      = idx_w;
        top_upd     = top_w;
        case (fds_pkg::action_t'(req.action))
            fds_pkg::ACT_PUSH:
            begin
                addr_w = top_w;
                if (top_w >= cap_w)
                begin
                    status_next = fds_pkg::ST_OVERFLOW;
                end
                else
                begin
                    ram_cmd.wr = accept;
                    top_upd    = top_w + CW'(1);
                end
            end
            fds_pkg::ACT_RESERVE:
            begin
                if (top_w + cnt_w > cap_w)
                begin
                    status_next = fds_pkg::ST_OVERFLOW;
                end
                else
                begin
                    top_upd = top_w + cnt_w;
                end
            end
            fds_pkg::ACT_POP:
            begin
                if (cnt_w > top_w)
                begin
                    status_next = fds_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    top_upd = top_w - cnt_w;
                end
            end
            fds_pkg::ACT_READ:
            begin
                if (idx_w >= top_w)
                begin
                    status_next = fds_pkg::ST_RANGE;
                end
                else
                begin
                    ram_cmd.rd = accept;
                    rd_ok_next = 1'b1;
                end
            end
            fds_pkg::ACT_WRITE:
            begin
                if (idx_w >= top_w)
                begin
                    status_next = fds_pkg::ST_RANGE;
                end
                else
                begin
                    ram_cmd.wr = accept;
                end
            end
            default:
            begin
                status_next = fds_pkg::ST_OK;
            end
        endcase
        top_next = accept ? top_upd[TW-1:0] : top_reg;
    end

    assign ram_addr  = addr_w[AW-1:0];
    assign ram_wdata = req.item_value[ITEM_WIDTH-1:0];

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            rd_ok_reg  <= rd_ok_next;
            depth_reg  <= top_upd[fds_pkg::DEPTH_W-1:0];
        end
    end

    always_comb
    begin
        rdata_ext                 = '0;
        rdata_ext[ITEM_WIDTH-1:0] = ram_rdata;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = rd_ok_reg ? rdata_ext : '0;
    assign rsp.depth     = depth_reg;
    assign rsp.status    = status_reg;

endmodule

[dv/frame_data_stack_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_data_stack_unit_tb
// Self-checking testbench for the frame data stack. A directed list covers
// the extreme fields, every action and the refusal cases. It is followed by
// random traffic that only reads slots holding defined data. A clocked driver
// feeds requests from a queue, and a clocked monitor checks each result
// against a stack kept in the testbench. Both sides idle in random bursts,
// and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module frame_data_stack_unit_tb;

    localparam int STACK_SLOTS     = fds_pkg::STACK_DEPTH_DEF;
    localparam int ITEM_BITS       = fds_pkg::ITEM_WIDTH_DEF;
    localparam int ACT_BITS        = fds_pkg::ACTION_W;
    localparam int VALUE_BITS      = fds_pkg::VALUE_W;
    localparam int COUNT_BITS      = fds_pkg::COUNT_W;
    localparam int INDEX_BITS      = fds_pkg::INDEX_W;
    localparam int DEPTH_BITS      = fds_pkg::DEPTH_W;
    localparam int RANDOM_REQUESTS = 1800;
    localparam int QUIET_TAIL      = 150;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AFTER      = 500;
    localparam logic [VALUE_BITS-1:0] ITEM_MASK =
        {VALUE_BITS{1'b1}} >> (VALUE_BITS - ITEM_BITS);

    typedef struct packed {
        logic [ACT_BITS-1:0]   act;
        logic [VALUE_BITS-1:0] val;
        logic [COUNT_BITS-1:0] cnt;
        logic [INDEX_BITS-1:0] idx;
    } stack_request_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] read_data;
        logic [DEPTH_BITS-1:0] depth;
        fds_pkg::status_t      status;
    } stack_outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;
    logic hold_results = 1'b0;

    fds_req_if req_ch();
    fds_rsp_if rsp_ch();

    frame_data_stack_unit #(
        .STACK_DEPTH(STACK_SLOTS),
        .ITEM_WIDTH (ITEM_BITS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    stack_request_t action_queue[$];
    stack_outcome_t outcome_queue[$];

    logic [VALUE_BITS-1:0] slot_mem [STACK_SLOTS];
    int                    slot_top;

    int  gen_top;
    bit  gen_written [STACK_SLOTS];

    int requests_planned;
    int requests_accepted;
    int results_checked;
    int error_count;
    int input_stall_cycles;
    int deepest;
    int unknown_tally;
    int action_tally [fds_pkg::ACT_WRITE + 1];
    int status_tally [fds_pkg::ST_RANGE + 1];
    int send_pause;
    int take_pause;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic stack_outcome_t stack_action_result(stack_request_t r);
        stack_outcome_t o;
        o.read_data = '0;
        o.status    = fds_pkg::ST_OK;
        case (r.act)
            fds_pkg::ACT_PUSH:
            begin
                if (slot_top >= STACK_SLOTS)
                begin
                    o.status = fds_pkg::ST_OVERFLOW;
                end
                else
                begin
                    slot_mem[slot_top] = r.val & ITEM_MASK;
                    slot_top++;
                end
            end
            fds_pkg::ACT_RESERVE:
            begin
                if (slot_top + r.cnt > STACK_SLOTS)
                begin
                    o.status = fds_pkg::ST_OVERFLOW;
                end
                else
                begin
                    slot_top += r.cnt;
                end
            end
            fds_pkg::ACT_POP:
            begin
                if (r.cnt > slot_top)
                begin
                    o.status = fds_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    slot_top -= r.cnt;
                end
            end
            fds_pkg::ACT_READ:
            begin
                if (r.idx >= slot_top)
                begin
                    o.status = fds_pkg::ST_RANGE;
                end
                else
                begin
                    o.read_data = slot_mem[r.idx];
                end
            end
            fds_pkg::ACT_WRITE:
            begin
                if (r.idx >= slot_top)
                begin
                    o.status = fds_pkg::ST_RANGE;
                end
                else
                begin
                    slot_mem[r.idx] = r.val & ITEM_MASK;
                end
            end
            default:
            begin
            end
        endcase
        o.depth = DEPTH_BITS'(slot_top);
        if (r.act <= fds_pkg::ACT_WRITE)
        begin
            action_tally[r.act]++;
        end
        else
        begin
            unknown_tally++;
        end
        status_tally[o.status]++;
        if (slot_top > deepest)
        begin
            deepest = slot_top;
        end
        return o;
    endfunction

    task automatic queue_request(input logic [ACT_BITS-1:0] act,
                                 input logic [VALUE_BITS-1:0] val,
                                 input logic [COUNT_BITS-1:0] cnt,
                                 input logic [INDEX_BITS-1:0] idx);
        stack_request_t r;
        r.act = act;
        r.val = val;
        r.cnt = cnt;
        r.idx = idx;
        action_queue.push_back(r);
        case (act)
            fds_pkg::ACT_PUSH:
            begin
                if (gen_top < STACK_SLOTS)
                begin
                    gen_written[gen_top] = 1'b1;
                    gen_top++;
                end
            end
            fds_pkg::ACT_RESERVE:
            begin
                if (gen_top + cnt <= STACK_SLOTS)
                begin
                    gen_top += cnt;
                end
            end
            fds_pkg::ACT_POP:
            begin
                if (cnt <= gen_top)
                begin
                    gen_top -= cnt;
                end
            end
            fds_pkg::ACT_WRITE:
            begin
                if (idx < gen_top)
                begin
                    gen_written[idx] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // A slot below the top may be read only once it holds a written value.
    function automatic bit choose_read_slot(output logic [INDEX_BITS-1:0] idx);
        int slot;
        if (gen_top == 0 || (gen_top < STACK_SLOTS && $urandom_range(0, 9) == 0))
        begin
            idx = INDEX_BITS'($urandom_range(gen_top, STACK_SLOTS - 1));
            return 1'b1;
        end
        for (int k = 0; k < 8; k++)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                slot = gen_top - 1 - $urandom_range(0, (gen_top > 8) ? 7 : gen_top - 1);
            end
            else
            begin
                slot = $urandom_range(0, gen_top - 1);
            end
            if (gen_written[slot])
            begin
                idx = INDEX_BITS'(slot);
                return 1'b1;
            end
        end
        if (gen_top < STACK_SLOTS)
        begin
            idx = INDEX_BITS'($urandom_range(gen_top, STACK_SLOTS - 1));
            return 1'b1;
        end
        idx = '0;
        return 1'b0;
    endfunction

    task automatic build_directed_requests();
        logic [VALUE_BITS-1:0] pattern_a;
        logic [VALUE_BITS-1:0] pattern_b;
        pattern_a = 64'hA5A5_5A5A_0F0F_F0F0;
        pattern_b = 64'h5555_AAAA_3333_CCCC;
        queue_request(fds_pkg::ACT_PUSH, '1, '1, '1);
        queue_request(fds_pkg::ACT_PUSH, '0, '0, '0);
        queue_request(fds_pkg::ACT_READ, '0, '0, 10'd0);
        queue_request(fds_pkg::ACT_READ, '1, '1, 10'd1);
        queue_request(fds_pkg::ACT_READ, '0, '0, 10'd2);
        queue_request(fds_pkg::ACT_WRITE, pattern_a, '0, 10'd1);
        queue_request(fds_pkg::ACT_READ, '0, '0, 10'd1);
        queue_request(fds_pkg::ACT_WRITE, pattern_b, '0, 10'd1023);
        queue_request(fds_pkg::ACT_READ, '0, '0, 10'd1023);
        queue_request(fds_pkg::ACT_RESERVE, '0, 11'd0, '0);
        queue_request(fds_pkg::ACT_POP, '0, 11'd0, '0);
        queue_request(fds_pkg::ACT_POP, '0, 11'd3, '0);
        queue_request(fds_pkg::ACT_RESERVE, '0, 11'd1023, '0);
        queue_request(fds_pkg::ACT_RESERVE, '0, 11'd1022, '0);
        queue_request(fds_pkg::ACT_PUSH, pattern_b, '0, '0);
        queue_request(fds_pkg::ACT_RESERVE, '0, 11'd1, '0);
        queue_request(fds_pkg::ACT_WRITE, pattern_b, '0, 10'd1023);
        queue_request(fds_pkg::ACT_READ, '0, '0, 10'd1023);
        queue_request(fds_pkg::ACT_POP, '0, 11'd1024, '0);
        queue_request(fds_pkg::ACT_READ, '0, '0, 10'd0);
        queue_request(fds_pkg::ACT_RESERVE, '0, 11'd1024, '0);
        queue_request(fds_pkg::ACT_READ, '0, '0, 10'd1023);
        queue_request(fds_pkg::ACT_READ, '0, '0, 10'd0);
        queue_request(fds_pkg::ACT_POP, '0, 11'd1024, '0);
        queue_request(fds_pkg::ACT_POP, '0, 11'd1, '0);
        for (int k = 1; k <= 3; k++)
        begin
            queue_request(ACT_BITS'(fds_pkg::ACT_WRITE + k), {$urandom, $urandom},
                          COUNT_BITS'($urandom), INDEX_BITS'($urandom));
        end
    endtask

    task automatic build_random_requests();
        logic [ACT_BITS-1:0]   act;
        logic [VALUE_BITS-1:0] val;
        logic [COUNT_BITS-1:0] cnt;
        logic [INDEX_BITS-1:0] idx;
        int pick;
        int sel;
        int counted;
        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            pick = $urandom_range(0, 99);
            sel  = $urandom_range(0, 99);
            val  = {$urandom, $urandom};
            if (sel < 8)
            begin
                val = '1;
            end
            else if (sel < 12)
            begin
                val = '0;
            end
            cnt = COUNT_BITS'($urandom_range(0, STACK_SLOTS));
            idx = INDEX_BITS'($urandom_range(0, STACK_SLOTS - 1));
            sel = $urandom_range(0, 99);
            if (pick < 28)
            begin
                act = fds_pkg::ACT_PUSH;
            end
            else if (pick < 38)
            begin
                act = fds_pkg::ACT_RESERVE;
                if (sel < 80)
                begin
                    cnt = COUNT_BITS'($urandom_range(0, 6));
                end
                else if (sel < 92)
                begin
                    cnt = COUNT_BITS'($urandom_range(0, STACK_SLOTS - gen_top));
                end
            end
            else if (pick < 53)
            begin
                act = fds_pkg::ACT_POP;
                if (sel < 75)
                begin
                    cnt = COUNT_BITS'($urandom_range(0, (gen_top < 6) ? gen_top : 6));
                end
                else if (sel < 85)
                begin
                    cnt = COUNT_BITS'(gen_top);
                end
            end
            else if (pick < 75)
            begin
                act = fds_pkg::ACT_READ;
                if (!choose_read_slot(idx))
                begin
                    act = fds_pkg::ACT_WRITE;
                end
            end
            else if (pick < 98)
            begin
                act = fds_pkg::ACT_WRITE;
                if (gen_top > 0 && sel < 85)
                begin
                    idx = INDEX_BITS'($urandom_range(0, gen_top - 1));
                end
            end
            else
            begin
                act = ACT_BITS'(fds_pkg::ACT_WRITE + $urandom_range(1, 3));
            end
            queue_request(act, val, cnt, idx);
            if (act <= fds_pkg::ACT_WRITE)
            begin
                counted++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        stack_request_t next_req;
        stack_request_t taken_req;
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.action     <= fds_pkg::ACT_PUSH;
            req_ch.item_value <= '0;
            req_ch.slot_count <= '0;
            req_ch.slot_index <= '0;
            send_pause = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                taken_req.act = req_ch.action;
                taken_req.val = req_ch.item_value;
                taken_req.cnt = req_ch.slot_count;
                taken_req.idx = req_ch.slot_index;
                outcome_queue.push_back(stack_action_result(taken_req));
                requests_accepted++;
            end
            else if (req_ch.valid)
            begin
                input_stall_cycles++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_pause > 0)
                begin
                    send_pause--;
                    req_ch.valid <= 1'b0;
                end
                else if (action_queue.size() > 0)
                begin
                    next_req = action_queue.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.action     <= next_req.act;
                    req_ch.item_value <= next_req.val;
                    req_ch.slot_count <= next_req.cnt;
                    req_ch.slot_index <= next_req.idx;
                    if (action_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                    begin
                        send_pause = $urandom_range(1, 16);
                    end
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        stack_outcome_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            take_pause = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (outcome_queue.size() == 0)
                begin
                    $error("result with no request outstanding: read_data %h depth %0d status %0d",
                           rsp_ch.read_data, rsp_ch.depth, rsp_ch.status);
                    error_count++;
                end
                else
                begin
                    want = outcome_queue.pop_front();
                    results_checked++;
                    if (rsp_ch.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, got %h", want.read_data,
                               rsp_ch.read_data);
                        error_count++;
                    end
                    if (rsp_ch.depth !== want.depth)
                    begin
                        $error("depth: expected %0d, got %0d", want.depth, rsp_ch.depth);
                        error_count++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        error_count++;
                    end
                end
            end
            if (hold_results)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else if (take_pause > 0)
            begin
                take_pause--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (action_queue.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
                begin
                    take_pause = $urandom_range(1, 16);
                end
            end
        end
    end

    initial
    begin
        wait (requests_accepted >= HOLD_AFTER);
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $error("timeout with %0d results outstanding", outcome_queue.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        build_directed_requests();
        build_random_requests();
        requests_planned = action_queue.size();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while (requests_accepted < requests_planned || outcome_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        $display("Checked %0d results: %0d push, %0d reserve, %0d pop, %0d read, %0d write,",
                 results_checked, action_tally[fds_pkg::ACT_PUSH],
                 action_tally[fds_pkg::ACT_RESERVE], action_tally[fds_pkg::ACT_POP],
                 action_tally[fds_pkg::ACT_READ], action_tally[fds_pkg::ACT_WRITE]);
        $display("%0d unknown; deepest stack %0d; refusals %0d overflow, %0d underflow,",
                 unknown_tally, deepest, status_tally[fds_pkg::ST_OVERFLOW],
                 status_tally[fds_pkg::ST_UNDERFLOW]);
        $display("%0d range; %0d input stall cycles.",
                 status_tally[fds_pkg::ST_RANGE], input_stall_cycles);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
hdl/fds_pkg.sv
hdl/fds_if.sv
hdl/fds_ram.sv
hdl/fds_ctrl.sv
hdl/frame_data_stack_unit.sv
dv/frame_data_stack_unit_tb.sv
